// ----- rtl/rtprs_pkg.sv -----
// rtprs_pkg: shared types and constants of the RTP reorder sequencer.
// No dependencies.
`default_nettype none
package rtprs_pkg;

  // ring depth; widths of the head index and the fill counter follow from it
  localparam int SLOTS = 64;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_FORCE  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IN_ORDER  = 3'd0,
    ST_SEQ_RESET = 3'd1,
    ST_OUT_ORDER = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_DELIVERED = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_WAITING   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_EXEC,
    BK_CLEAR
  } back_state_e;

  localparam logic [6:0] WAIT_RESET = 7'd10;

  typedef struct packed {
    logic       is_insert;
    logic       forced;
    logic [15:0] seq;
    logic [15:0] tag;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/rtp_reorder_sequencer_unit.sv -----
// rtp_reorder_sequencer_unit: top level of the RTP reorder sequencer.
// Depends on rtprs_pkg, rtprs_front, rtprs_back.
//
// Usage:
//  - Command channel: pulse start with func_i/seq_i/tag_i while busy is low;
//    that edge is the transfer. func 0 inserts, 1 pops, 2 forces a pop,
//    3 is ignored and yields no result.
//  - Result channel: done_o is high for one cycle with status_o, out_seq_o,
//    out_tag_o, ext_seq_o, lost_total_o, head_ready_o and fill_o. The
//    receiver cannot stall; results must be taken in that cycle.
//  - Config channel: cfg_valid_i/cfg_ready_o write wait_threshold (reset 10).
//    Ready is high only while the back end is idle and the front queue is
//    empty, so a write never lands under a command in flight.
//  - Sequence: an insert or a pop that hits the head passes the queue, read,
//    scan and execute steps before done_o rises. A skipping pop scans the
//    valid bits one slot per cycle from the head before it executes.
//  - One command is in flight at a time; the one-entry front queue frees
//    when the back end executes, so busy drops in the done_o cycle and the
//    next transfer can follow at its end.
//  - Reset clears all slot valid bits, counters and the expected sequence
//    at once; slot contents need no clearing.
`default_nettype none
module rtp_reorder_sequencer_unit #(
  parameter int TAG_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] seq_i,
  input  wire logic [15:0] tag_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      out_seq_o,
  output logic [15:0]      out_tag_o,
  output logic [31:0]      ext_seq_o,
  output logic [31:0]      lost_total_o,
  output logic             head_ready_o,
  output logic [6:0]       fill_o
);
  logic [6:0]      thr_q;
  logic            q_valid, q_take, idle;
  rtprs_pkg::cmd_t q_cmd;

  assign cfg_ready_o = idle && !q_valid;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= rtprs_pkg::WAIT_RESET;
    else if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
  end

  rtprs_front u_front (
    .clk_i, .rst_ni, .start, .func_i, .seq_i, .tag_i, .busy,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_take_i(q_take)
  );

  rtprs_back #(.TAG_BITS(TAG_BITS)) u_back (
    .clk_i, .rst_ni, .wait_thr_i(thr_q),
    .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_take_o(q_take), .idle_o(idle),
    .done_o, .status_o, .out_seq_o, .out_tag_o, .ext_seq_o, .lost_total_o,
    .head_ready_o, .fill_o
  );
endmodule
`default_nettype wire

// ----- rtl/rtprs_front.sv -----
// rtprs_front: accepts commands, drops unknown functions, holds a one-entry queue.
// Depends on rtprs_pkg.
`default_nettype none
module rtprs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [1:0]        func_i,
  input  wire logic [15:0]       seq_i,
  input  wire logic [15:0]       tag_i,
  output logic                   busy,
  output logic                   q_valid_o,
  output rtprs_pkg::cmd_t        q_cmd_o,
  input  wire logic              q_take_i
);
  logic            valid_q, valid_d;
  rtprs_pkg::cmd_t cmd_q;
  logic            acc;

  assign busy = valid_q;
  assign acc  = start && !valid_q;

  always_comb begin
    valid_d = valid_q;
    if (q_take_i) valid_d = 1'b0;
    if (acc && rtprs_pkg::func_e'(func_i) != rtprs_pkg::FUNC_NONE) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q.is_insert <= rtprs_pkg::func_e'(func_i) == rtprs_pkg::FUNC_INSERT;
      cmd_q.forced    <= rtprs_pkg::func_e'(func_i) == rtprs_pkg::FUNC_FORCE;
      cmd_q.seq       <= seq_i;
      cmd_q.tag       <= tag_i;
    end
  end

  assign q_valid_o = valid_q;
  assign q_cmd_o   = cmd_q;
endmodule
`default_nettype wire

// ----- rtl/rtprs_back.sv -----
// rtprs_back: slot ring, scan for earliest, insert and pop execution.
// Depends on rtprs_pkg.
`default_nettype none
module rtprs_back #(
  parameter int TAG_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [6:0]        wait_thr_i,
  input  wire logic              q_valid_i,
  input  rtprs_pkg::cmd_t        q_cmd_i,
  output logic                   q_take_o,
  output logic                   idle_o,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [15:0]            out_seq_o,
  output logic [15:0]            out_tag_o,
  output logic [31:0]            ext_seq_o,
  output logic [31:0]            lost_total_o,
  output logic                   head_ready_o,
  output logic [6:0]             fill_o
);
  localparam int SLOTS = rtprs_pkg::SLOTS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

  rtprs_pkg::back_state_e st_q, st_d;
  logic [SLOTS-1:0] valid_q;
  logic [15:0]      mseq [SLOTS];
  logic [TW-1:0]    mtag [SLOTS];
  logic [15:0]      rd_seq_q;
  logic [TW-1:0]    rd_tag_q;
  logic [IW-1:0]    rd_addr;

  rtprs_pkg::cmd_t cmd_q;
  logic [15:0]   exp_q;
  logic          known_q;
  logic [IW-1:0] head_q, ix_q, scan_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   roll_q;
  logic [31:0]   last_q, lost_q;
  logic          found_q;

  logic          head_v;
  logic [6:0]    thr;
  logic [CW:0]   cnt_w;
  logic [IW-1:0] scan_ix;

  assign head_v  = valid_q[head_q];
  assign thr     = cmd_q.forced ? 7'd0 : wait_thr_i;
  assign cnt_w   = {1'b0, cnt_q};
  assign scan_ix = IW'((32'(head_q) + 32'(scan_q)) % SLOTS);

  // scan ends on the cycle that sees a valid slot, so the read of that
  // slot lands in rd_seq_q on the same edge
  always_comb begin
    st_d = st_q;
    case (st_q)
      rtprs_pkg::BK_IDLE: if (q_valid_i) st_d = rtprs_pkg::BK_READ;
      rtprs_pkg::BK_READ: st_d = rtprs_pkg::BK_SCAN;
      rtprs_pkg::BK_SCAN: begin
        if (found_q || valid_q[scan_ix] || scan_q == IW'(SLOTS - 1))
          st_d = rtprs_pkg::BK_EXEC;
      end
      rtprs_pkg::BK_EXEC: st_d = rtprs_pkg::BK_IDLE;
      default: st_d = rtprs_pkg::BK_IDLE;
    endcase
  end

  assign q_take_o = (st_q == rtprs_pkg::BK_EXEC);
  assign idle_o   = (st_q == rtprs_pkg::BK_IDLE);

  // read address: scan walks from the head; otherwise the chosen slot
  always_comb begin
    rd_addr = ix_q;
    if (st_q == rtprs_pkg::BK_SCAN) rd_addr = scan_ix;
  end

  // per-item command latch and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rtprs_pkg::BK_IDLE;
      scan_q <= '0; found_q <= 1'b0; ix_q <= '0; cmd_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        rtprs_pkg::BK_IDLE: begin
          scan_q <= '0; found_q <= 1'b0; cmd_q <= q_cmd_i;
        end
        rtprs_pkg::BK_READ: begin
          ix_q    <= head_q;
          found_q <= cmd_q.is_insert || head_v;
        end
        rtprs_pkg::BK_SCAN: begin
          if (!found_q) begin
            if (valid_q[scan_ix]) begin
              found_q <= 1'b1; ix_q <= scan_ix;
            end else scan_q <= scan_q + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // slot memory: registered read, written in EXEC
  logic          wr_en;
  logic [IW-1:0] wr_ix;
  always_ff @(posedge clk_i) begin
    rd_seq_q <= mseq[rd_addr];
    rd_tag_q <= mtag[rd_addr];
    if (wr_en) begin
      mseq[wr_ix] <= cmd_q.seq;
      mtag[wr_ix] <= cmd_q.tag[TW-1:0];
    end
  end

  // execute step
  logic [15:0]   e_base, e_ofs;
  logic          e_far, e_late;
  logic [IW-1:0] e_ix;
  logic          pop_ok;
  logic [2:0]    st_code;
  logic [15:0]   hi;
  logic [15:0]   roll_n;
  logic [31:0]   ext;
  logic [15:0]   gap;
  logic [SLOTS-1:0] valid_n;
  logic [CW-1:0] cnt_n;

  assign e_base = known_q ? exp_q : cmd_q.seq;
  assign e_ofs  = cmd_q.seq - e_base;
  assign e_far  = e_ofs >= 16'(SLOTS);
  assign e_late = e_far && ({1'b0, e_ofs} + 17'(SLOTS) > 17'h10000);
  assign e_ix   = e_far ? head_q : IW'((32'(head_q) + 32'(e_ofs)) % SLOTS);
  assign hi     = last_q[31:16];
  // skipped numbers, modulo 2^16
  assign gap    = rd_seq_q - exp_q;

  always_comb begin
    valid_n = valid_q;
    cnt_n   = cnt_q;
    pop_ok  = 1'b0;
    wr_en   = 1'b0;
    wr_ix   = e_ix;
    st_code = rtprs_pkg::ST_IN_ORDER;
    roll_n  = roll_q;
    if (cmd_q.is_insert) begin
      if (e_late) st_code = rtprs_pkg::ST_REJECTED;
      else begin
        if (e_far) begin
          valid_n = '0; cnt_n = '0;
        end
        if (valid_n[e_ix]) st_code = rtprs_pkg::ST_REJECTED;
        else begin
          wr_en = (st_q == rtprs_pkg::BK_EXEC);
          valid_n[e_ix] = 1'b1;
          cnt_n = cnt_n + CW'(1);
          if (e_far) st_code = rtprs_pkg::ST_SEQ_RESET;
          else if (e_ix != head_q) st_code = rtprs_pkg::ST_OUT_ORDER;
        end
      end
    end else begin
      if (valid_q[head_q]) pop_ok = 1'b1;
      else if (cnt_q == '0) st_code = rtprs_pkg::ST_EMPTY;
      else if (cnt_w < (CW+1)'(thr)) st_code = rtprs_pkg::ST_WAITING;
      else if (!found_q) st_code = rtprs_pkg::ST_EMPTY;
      else pop_ok = 1'b1;
      if (pop_ok) begin
        st_code = rtprs_pkg::ST_DELIVERED;
        valid_n[ix_q] = 1'b0;
        cnt_n = cnt_q - CW'(1);
        if (roll_q < hi || (roll_q == hi && rd_seq_q < last_q[15:0]))
          roll_n = (rd_seq_q >= last_q[15:0]) ? hi : hi + 16'd1;
      end
    end
    ext = {roll_n, rd_seq_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; exp_q <= '0; known_q <= 1'b0; head_q <= '0; cnt_q <= '0;
      roll_q <= '0; last_q <= '0; lost_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= (st_q == rtprs_pkg::BK_EXEC);
      if (st_q == rtprs_pkg::BK_EXEC) begin
        valid_q <= valid_n;
        cnt_q   <= cnt_n;
        if (cmd_q.is_insert) begin
          if (!known_q) known_q <= 1'b1;
          if (!known_q || (e_far && !e_late)) exp_q <= cmd_q.seq;
        end else if (pop_ok) begin
          lost_q <= lost_q + {16'd0, gap};
          exp_q  <= rd_seq_q + 16'd1;
          head_q <= IW'((32'(ix_q) + 1) % SLOTS);
          roll_q <= roll_n;
          last_q <= ext;
        end
      end
    end
  end

  // result register; head_ready and fill use the post-step state
  logic [IW-1:0] head_n;
  assign head_n = (!cmd_q.is_insert && pop_ok) ? IW'((32'(ix_q) + 1) % SLOTS) : head_q;
  always_ff @(posedge clk_i) begin
    if (st_q == rtprs_pkg::BK_EXEC) begin
      status_o     <= st_code;
      out_seq_o    <= pop_ok ? rd_seq_q : 16'd0;
      out_tag_o    <= pop_ok ? 16'(rd_tag_q) : 16'd0;
      ext_seq_o    <= pop_ok ? ext : 32'd0;
      lost_total_o <= pop_ok ? lost_q + {16'd0, gap} : lost_q;
      head_ready_o <= valid_n[head_n];
      fill_o       <= 7'(cnt_n);
    end
  end
endmodule
`default_nettype wire
